// ===== hdl/sbf_pkg.sv =====
// shared types and constants for the slot bitmap free/last finder
// no dependencies; imported by sbf_scan and the top module
`default_nettype none

package sbf_pkg;

  localparam int TABLE_BYTES_DEF = 128;

  localparam int KIND_W     = 2;
  localparam int ADDR_W     = 7;
  localparam int BYTE_W     = 8;
  localparam int SID_W      = 10;
  localparam int ID_W       = 11;
  localparam int LIM_W      = 12;
  localparam int STAT_W     = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  // request kinds, code 3 is unused
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LAST  = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_READY = 2'd1,
    STAT_FULL      = 2'd2
  } stat_t;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_READY    = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0] capacity;
    logic            ready;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SID_W-1:0]  end_id;
    logic [SID_W-1:0]  start_slot;
    logic [BYTE_W-1:0] map_byte;
    logic [ADDR_W-1:0] byte_addr;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] result_id;
    stat_t           status;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/sbf_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module sbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/sbf_scan.sv =====
// request sequencer: byte writes, free-slot scan and last-filled scan
// over the bitmap ram; uses sbf_pkg
`default_nettype none

module sbf_scan #(
  parameter int TABLE_BYTES = sbf_pkg::TABLE_BYTES_DEF,
  localparam int AW = (TABLE_BYTES > 1) ? $clog2(TABLE_BYTES) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sbf_pkg::cfg_t        cfg,
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire sbf_pkg::req_t        req,
  input  wire logic [7:0]           rd_byte,
  output logic                      mem_rd_en,
  output logic [AW-1:0]             mem_rd_addr,
  output logic                      mem_we,
  output logic [AW-1:0]             mem_wa,
  output logic [7:0]                mem_wd,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output sbf_pkg::res_t             res
);

  import sbf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  localparam logic [LIM_W-1:0] SLOTS    = LIM_W'(TABLE_BYTES * 8);
  localparam logic [8:0]       TB9      = 9'(TABLE_BYTES);
  localparam logic [8:0]       TOP_MAX  = 9'(TABLE_BYTES - 1);

  state_t            state_r, state_nxt;
  logic              free_r, free_nxt;
  logic [AW-1:0]     cur_r, cur_nxt;
  logic [AW-1:0]     first_r, first_nxt;
  logic              more_r, more_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pidx_r, pidx_nxt;
  logic [LIM_W-1:0]  limit_r, limit_nxt;
  logic [SID_W-1:0]  start_r, start_nxt;
  res_t              res_r, res_nxt;

  logic [LIM_W-1:0]  limit_c;
  logic [8:0]        last9, top9, first9;
  logic              accept;
  logic [2:0]        zb;
  logic              any_zero;
  logic [LIM_W-1:0]  slot12;
  logic              hit;
  logic [LIM_W-1:0]  est;
  logic [ID_W-1:0]   last_id;
  logic [AW:0]       cur_inc;

  assign accept    = req_valid && req_ready;
  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  assign limit_c = ({1'b0, cfg.capacity} > SLOTS) ? SLOTS : {1'b0, cfg.capacity};
  assign first9  = {2'b00, req.start_slot[SID_W-1:3]};
  assign last9   = {2'b00, req.end_id[SID_W-1:3]};
  assign top9    = (last9 < TOP_MAX) ? last9 : TOP_MAX;

  // lowest clear bit of the byte just read
  always_comb begin
    zb = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!rd_byte[i]) begin
        zb = 3'(i);
      end
    end
  end

  assign any_zero = (rd_byte != 8'hFF);
  assign slot12   = LIM_W'({pidx_r, zb});
  assign hit      = free_r ? (any_zero && (slot12 < limit_r)) : (rd_byte != 8'h00);
  assign est      = LIM_W'({pidx_r, 3'b000}) + LIM_W'(8);
  assign last_id  = (est >= {1'b0, cfg.capacity}) ? cfg.capacity : est[ID_W-1:0];
  assign cur_inc  = {1'b0, cur_r} + (AW+1)'(1);

  assign mem_wa      = AW'(req.byte_addr);
  assign mem_wd      = req.map_byte;
  assign mem_rd_addr = cur_r;

  always_comb begin
    state_nxt = state_r;
    free_nxt  = free_r;
    cur_nxt   = cur_r;
    first_nxt = first_r;
    more_nxt  = more_r;
    pend_nxt  = pend_r;
    pidx_nxt  = pidx_r;
    limit_nxt = limit_r;
    start_nxt = start_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_rd_en = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt   = '{result_id: '0, status: STAT_OK};
          state_nxt = S_DONE;
          pend_nxt  = 1'b0;
          limit_nxt = limit_c;
          start_nxt = req.start_slot;
          case (req.kind)
            KIND_WRITE: begin
              mem_we = ({2'b00, req.byte_addr} < TB9);
            end
            KIND_FREE, KIND_LAST: begin
              if (!cfg.ready) begin
                res_nxt.status = STAT_NOT_READY;
              end else if (req.kind == KIND_FREE) begin
                if (limit_c == '0) begin
                  res_nxt.status = STAT_FULL;
                end else begin
                  free_nxt  = 1'b1;
                  cur_nxt   = '0;
                  more_nxt  = 1'b1;
                  state_nxt = S_SCAN;
                end
              end else begin
                if (first9 > top9) begin
                  res_nxt.result_id = {1'b0, req.start_slot};
                end else begin
                  // walk down from the top byte, first nonzero one wins
                  free_nxt  = 1'b0;
                  cur_nxt   = AW'(top9);
                  first_nxt = AW'(first9);
                  more_nxt  = 1'b1;
                  state_nxt = S_SCAN;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        // issue the next read while checking the byte of the previous one
        mem_rd_en = more_r;
        pend_nxt  = more_r;
        pidx_nxt  = cur_r;
        if (more_r) begin
          if (free_r) begin
            cur_nxt  = cur_inc[AW-1:0];
            more_nxt = (LIM_W'({cur_inc, 3'b000}) < limit_r);
          end else begin
            cur_nxt  = cur_r - AW'(1);
            more_nxt = (cur_r != first_r);
          end
        end
        if (pend_r) begin
          if (hit) begin
            res_nxt.status    = STAT_OK;
            res_nxt.result_id = free_r ? slot12[ID_W-1:0] : last_id;
            state_nxt         = S_DONE;
          end else if (!more_r) begin
            res_nxt.status    = free_r ? STAT_FULL : STAT_OK;
            res_nxt.result_id = free_r ? '0 : {1'b0, start_r};
            state_nxt         = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      more_r  <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      more_r  <= more_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    free_r  <= free_nxt;
    cur_r   <= cur_nxt;
    first_r <= first_nxt;
    pidx_r  <= pidx_nxt;
    limit_r <= limit_nxt;
    start_r <= start_nxt;
    res_r   <= res_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/slot_bitmap_free_and_last_finder.sv =====
// slot occupancy bitmap with free-slot and last-filled finders
// channels:
//   in_*  : one request per transfer; in_tuser is the kind (0 write byte,
//           1 find first free, 2 find last filled), in_tdata the operands
//   out_* : one response per request, in request order; out_tuser is the
//           status (0 ok, 1 not ready, 2 no free slot), out_tdata the slot id
//   cfg_* : register 0 slot capacity, register 1 ready flag
// one request is worked on at a time. a write, a refused query or an empty
// range goes to the result register on acceptance and then on to the output
// register, and the next request is taken once the sequencer is idle. a free query
// reads one bitmap byte per cycle from the ram, ceil(min(capacity, 8*TABLE_BYTES)/8)
// bytes at most, before its response is out; a last-filled query walks down from
// the top byte of its range, reading at most the bytes of the range. the next
// request is taken once the response has left for the output register. the single
// ram read port sets the pace.
// a finished response sits in the output register, so the next request is
// taken while the receiver stalls; a second response waits inside.
// reset clears the registers and the per-byte valid flags, so the bitmap
// reads as all zero at once; there is no clearing pass.
`default_nettype none

module slot_bitmap_free_and_last_finder #(
  parameter int TABLE_BYTES = sbf_pkg::TABLE_BYTES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // byte_addr[6:0], map_byte[14:7], start_slot[24:15], end_id[34:25], zero pad
  input  wire logic [sbf_pkg::IN_DATA_W-1:0]      in_tdata,
  // kind[1:0]
  input  wire logic [sbf_pkg::KIND_W-1:0]         in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // result_id[10:0], zero pad
  output logic      [sbf_pkg::OUT_DATA_W-1:0]     out_tdata,
  // status[1:0]
  output logic      [sbf_pkg::STAT_W-1:0]         out_tuser,
  input  wire logic                               cfg_we,
  input  wire logic [sbf_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  wire logic [sbf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  import sbf_pkg::*;

  localparam int AW = (TABLE_BYTES > 1) ? $clog2(TABLE_BYTES) : 1;

  cfg_t             cfg_r;
  req_t             req;
  res_t             res;
  logic             res_valid;
  logic             res_ready;
  logic             mem_rd_en;
  logic [AW-1:0]    mem_rd_addr;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [7:0]       mem_wd;
  logic [7:0]       ram_q;
  logic [7:0]       rd_byte;
  logic [TABLE_BYTES-1:0] vld_r;
  logic             vld_q_r;
  logic             out_valid_r;
  res_t             out_res_r;

  assign req.kind       = in_tuser;
  assign req.byte_addr  = in_tdata[6:0];
  assign req.map_byte   = in_tdata[14:7];
  assign req.start_slot = in_tdata[24:15];
  assign req.end_id     = in_tdata[34:25];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_CAPACITY: cfg_r.capacity <= cfg_wdata;
        CFG_READY:    cfg_r.ready    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  sbf_scan #(
    .TABLE_BYTES(TABLE_BYTES)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .req_valid   (in_tvalid),
    .req_ready   (in_tready),
    .req         (req),
    .rd_byte     (rd_byte),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_we      (mem_we),
    .mem_wa      (mem_wa),
    .mem_wd      (mem_wd),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  sbf_ram #(
    .WIDTH(8),
    .DEPTH(TABLE_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (mem_wd),
    .re    (mem_rd_en),
    .raddr (mem_rd_addr),
    .rdata (ram_q)
  );

  // a byte never written since reset reads as zero; writes and scans
  // never overlap, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[mem_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd_en) begin
      vld_q_r <= vld_r[mem_rd_addr];
    end
  end

  assign rd_byte = vld_q_r ? ram_q : 8'h00;

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_res_r.result_id);
  assign out_tuser  = out_res_r.status;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request taken while previous one still in progress");

  a_read_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    mem_rd_en |-> !in_tready)
    else $error("bitmap read outside a scan");

  a_full_has_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == STAT_FULL || out_tuser == STAT_NOT_READY))
      |-> (out_tdata == '0))
    else $error("error response carries a nonzero slot id");

endmodule

`default_nettype wire

// ===== tb/sv/tb_slot_bitmap_free_and_last_finder.sv =====
`timescale 1ns / 1ps
// testbench for slot_bitmap_free_and_last_finder: directed corners, a long output stall
// and random request traffic, each response checked against an in-bench bitmap model
// depends on sbf_pkg and the block's rtl only

module tb_slot_bitmap_free_and_last_finder;
  import sbf_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int MAP_BYTES   = TABLE_BYTES_DEF;
  localparam int MAP_SLOTS   = 8 * MAP_BYTES;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_GAP   = 150;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [KIND_W-1:0]     in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]     out_tuser;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // bitmap and register copies used to predict each response
  logic [BYTE_W-1:0] slot_map [MAP_BYTES];
  logic [ID_W-1:0]   capacity_q;
  logic              ready_q;
  res_t              pending_responses [$];

  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;
  int unsigned stall_left   = 0;

  slot_bitmap_free_and_last_finder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: long hold-off when requested, otherwise random stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  function automatic res_t compute_response(input req_t r);
    res_t        rsp;
    int unsigned lim;
    int unsigned i;
    int unsigned n;
    int unsigned top;
    int unsigned est;
    bit          hit;
    rsp.result_id = '0;
    rsp.status    = STAT_OK;
    if (r.kind == KIND_WRITE) begin
      if (r.byte_addr < MAP_BYTES) slot_map[r.byte_addr] = r.map_byte;
    end else if (r.kind == KIND_FREE || r.kind == KIND_LAST) begin
      if (!ready_q) begin
        rsp.status = STAT_NOT_READY;
      end else if (r.kind == KIND_FREE) begin
        lim = (capacity_q > MAP_SLOTS) ? MAP_SLOTS : capacity_q;
        rsp.status = STAT_FULL;
        for (i = 0; i < lim; i++) begin
          if (!slot_map[i >> 3][i & 7]) begin
            rsp.result_id = ID_W'(i);
            rsp.status    = STAT_OK;
            break;
          end
        end
      end else begin
        hit = 1'b0;
        top = 0;
        for (n = r.start_slot >> 3; n <= (r.end_id >> 3); n++) begin
          if (n < MAP_BYTES && slot_map[n] != '0) begin
            top = n;
            hit = 1'b1;
          end
        end
        if (!hit) begin
          rsp.result_id = ID_W'(r.start_slot);
        end else begin
          est = (top + 1) * 8;
          if (est >= capacity_q) est = capacity_q;
          rsp.result_id = ID_W'(est);
        end
      end
    end
    return rsp;
  endfunction

  task automatic flag_mismatch(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    if (mismatches < 10)
      $display("mismatch on %s: expected %h, got %h (cycle %0d)", what, want, got, cycle_count);
    mismatches++;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_responses.size() == 0) begin
        flag_mismatch("response with nothing pending", 16'h0, out_tdata);
      end else begin
        want = pending_responses.pop_front();
        if (out_tdata[ID_W-1:0] !== want.result_id)
          flag_mismatch("result_id", 16'(want.result_id), 16'(out_tdata[ID_W-1:0]));
        if (out_tuser !== want.status)
          flag_mismatch("status", 16'(want.status), 16'(out_tuser));
      end
    end
  end

  // valid stays high from one request to the next unless the sender idles
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr,
                              input logic [BYTE_W-1:0] value,
                              input logic [SID_W-1:0] first_slot,
                              input logic [SID_W-1:0] last_slot);
    req_t r;
    r.kind       = kind;
    r.byte_addr  = addr;
    r.map_byte   = value;
    r.start_slot = first_slot;
    r.end_id     = last_slot;
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - ADDR_W - BYTE_W - 2 * SID_W){1'b0}},
                  last_slot, first_slot, value, addr};
    in_tuser  <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_responses.push_back(compute_response(r));
  endtask

  task automatic wait_for_idle();
    in_tvalid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CAPACITY) capacity_q = value;
    else ready_q = value[0];
  endtask

  // upper bits of the ready word are noise, only bit 0 counts
  task automatic configure(input int unsigned cap, input bit rdy);
    logic [CFG_DATA_W-1:0] flag_word;
    flag_word    = CFG_DATA_W'($urandom_range((1 << CFG_DATA_W) - 1));
    flag_word[0] = rdy;
    write_reg(CFG_CAPACITY, CFG_DATA_W'(cap));
    write_reg(CFG_READY, flag_word);
  endtask

  task automatic send_random_request(input int unsigned hot_bytes);
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] value;
    logic [SID_W-1:0]  lo_slot;
    logic [SID_W-1:0]  hi_slot;
    logic [SID_W-1:0]  swap;
    int unsigned       pick;
    pick = $urandom_range(99);
    if (pick < 50) kind = KIND_WRITE;
    else if (pick < 75) kind = KIND_FREE;
    else if (pick < 95) kind = KIND_LAST;
    else kind = KIND_UNUSED;
    // writes mostly land inside the capacity so free scans go deep
    addr = ($urandom_range(3) == 0) ? ADDR_W'($urandom_range(MAP_BYTES - 1))
                                    : ADDR_W'($urandom_range(hot_bytes));
    pick = $urandom_range(9);
    if (pick < 6) value = 8'hFF;
    else if (pick == 6) value = 8'h00;
    else value = BYTE_W'($urandom_range(255));
    lo_slot = SID_W'($urandom_range(MAP_SLOTS - 1));
    hi_slot = SID_W'($urandom_range(MAP_SLOTS - 1));
    if ($urandom_range(3) != 0 && lo_slot > hi_slot) begin
      swap    = lo_slot;
      lo_slot = hi_slot;
      hi_slot = swap;
    end
    send_request(kind, addr, value, lo_slot, hi_slot);
  endtask

  // mark every slot within capacity used, then punch one hole and look again
  task automatic fill_then_probe(input int unsigned nbytes);
    int unsigned n;
    for (n = 0; n < nbytes; n++)
      send_request(KIND_WRITE, ADDR_W'(n), 8'hFF, SID_W'($urandom_range(MAP_SLOTS - 1)),
                   SID_W'($urandom_range(MAP_SLOTS - 1)));
    send_request(KIND_FREE, ADDR_W'($urandom_range(MAP_BYTES - 1)),
                 BYTE_W'($urandom_range(255)),
                 SID_W'($urandom_range(MAP_SLOTS - 1)), SID_W'($urandom_range(MAP_SLOTS - 1)));
    send_request(KIND_WRITE, ADDR_W'($urandom_range(nbytes - 1)),
                 ~(8'h01 << $urandom_range(7)), '0, '0);
    send_request(KIND_FREE, '0, '0, '0, '0);
    send_request(KIND_LAST, '0, '0, '0, '1);
  endtask

  task automatic test_directed_corners();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    // registers still at reset: queries refused, writes and unused kind pass through
    send_request(KIND_FREE, '0, '0, '0, '0);
    send_request(KIND_LAST, '1, '1, '0, '1);
    send_request(KIND_WRITE, '0, 8'hFF, '1, '1);
    send_request(KIND_UNUSED, '1, '1, '1, '1);
    wait_for_idle();
    configure(0, 1'b1);
    send_request(KIND_FREE, '1, '0, '1, '0);
    send_request(KIND_LAST, '0, '0, '0, '1);
    wait_for_idle();
    configure(MAP_SLOTS, 1'b1);
    send_request(KIND_FREE, '0, '0, '0, '0);
    send_request(KIND_WRITE, '1, 8'h80, '0, '0);
    send_request(KIND_LAST, '0, '0, '0, '1);
    // start byte above end byte scans nothing
    send_request(KIND_LAST, '0, '0, '1, '0);
    send_request(KIND_LAST, '0, '0, 10'd8, 10'd1015);
    send_request(KIND_WRITE, 7'd1, 8'h55, '0, '0);
    send_request(KIND_FREE, '0, '0, '0, '0);
    send_request(KIND_UNUSED, '0, '0, '0, '0);
    wait_for_idle();
    configure(16, 1'b1);
    send_request(KIND_WRITE, 7'd1, 8'hFF, '0, '0);
    send_request(KIND_FREE, '0, '0, '0, '0);
    send_request(KIND_LAST, '0, '0, '0, '1);
    send_request(KIND_WRITE, '1, 8'h00, '0, '0);
    send_request(KIND_LAST, '0, '0, '0, '1);
    wait_for_idle();
    configure(MAP_SLOTS, 1'b0);
    send_request(KIND_FREE, '0, '0, '0, '0);
    send_request(KIND_LAST, '0, '0, '0, '1);
    wait_for_idle();
  endtask

  task automatic test_output_backpressure();
    int unsigned k;
    wait_for_idle();
    configure(MAP_SLOTS, 1'b1);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    stall_left   = 400;
    for (k = 0; k < 24; k++) send_random_request(MAP_BYTES - 1);
    // sender holds off until everything is back
    wait_for_idle();
  endtask

  task automatic test_random_traffic(input int unsigned in_pct, input int unsigned out_pct,
                                     input int unsigned batches, input int unsigned per_batch);
    int unsigned b;
    int unsigned k;
    int unsigned cap;
    int unsigned hot;
    bit          rdy;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    for (b = 0; b < batches; b++) begin
      wait_for_idle();
      case ($urandom_range(9))
        0: cap = 0;
        1: cap = 1;
        2: cap = MAP_SLOTS;
        3: cap = MAP_SLOTS - 1;
        4: cap = $urandom_range(64, 1);
        default: cap = $urandom_range(MAP_SLOTS);
      endcase
      rdy = ($urandom_range(9) != 0);
      configure(cap, rdy);
      hot = (cap + 7) / 8;
      if (hot > MAP_BYTES - 1) hot = MAP_BYTES - 1;
      if (cap != 0 && $urandom_range(4) == 0) fill_then_probe((cap + 7) / 8);
      for (k = 0; k < per_batch; k++) send_random_request(hot);
    end
  endtask

  initial begin
    foreach (slot_map[i]) slot_map[i] = '0;
    capacity_q = '0;
    ready_q    = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_corners();
    test_output_backpressure();
    test_random_traffic(17, 69, 6, 62);
    test_random_traffic(69, 17, 6, 62);
    test_random_traffic(0, 0, 6, 62);
    wait_for_idle();
    repeat (DRAIN_GAP) @(posedge clk);
    if (mismatches == 0 && pending_responses.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
